### hw/rtl/mftr_pkg.sv
`default_nettype none

package mftr_pkg;

  // Phase codes reported in the result
  localparam logic [2:0] PhWaitA  = 3'd0;
  localparam logic [2:0] PhSawA   = 3'd1;
  localparam logic [2:0] PhHeader = 3'd2;
  localparam logic [2:0] PhBody   = 3'd3;
  localparam logic [2:0] PhDone   = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CfgBaseTone  = 3'd0;
  localparam logic [2:0] CfgSpacing   = 3'd1;
  localparam logic [2:0] CfgGuardA    = 3'd2;
  localparam logic [2:0] CfgGuardB    = 3'd3;
  localparam logic [2:0] CfgTolerance = 3'd4;

  typedef struct packed {
    logic        mode;
    logic [14:0] freq_hz;
  } in_item_t;

  typedef struct packed {
    logic [2:0] phase;
    logic       tone_accepted;
    logic       byte_valid;
    logic [7:0] byte_value;
    logic       byte_last;
    logic [7:0] body_length;
  } out_item_t;

  typedef struct packed {
    logic [14:0] base_tone_hz;
    logic [12:0] tone_spacing_hz;
    logic [14:0] guard_a_hz;
    logic [14:0] guard_b_hz;
    logic [11:0] match_tolerance_hz;
  } cfg_t;

  // Median scan result, done is a one-cycle pulse
  typedef struct packed {
    logic        done;
    logic [14:0] value;
  } med_res_t;

  // Tone search result, done is a one-cycle pulse
  typedef struct packed {
    logic       done;
    logic       hit;
    logic       is_data;
    logic       eq_guard_a;
    logic       eq_guard_b;
    logic [7:0] sym;
  } tone_res_t;

endpackage

`default_nettype wire

### hw/rtl/mftr_median.sv
`default_nettype none

// Sliding sample window with a rank-scan median: one candidate per cycle while
// no push or clear arrives, compared against every entry at once.
module mftr_median #(
  parameter int unsigned WINDOW = 9
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              clear_i,
  input  wire logic              push_i,
  input  wire logic [14:0]       push_data_i,
  output mftr_pkg::med_res_t     res_o
);

  localparam int unsigned PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CW = $clog2(WINDOW + 1);
  localparam logic [CW-1:0] Mid = CW'(WINDOW / 2);
  localparam logic [PW-1:0] LastPos = PW'(WINDOW - 1);

  logic [14:0]        win_q [WINDOW];
  logic [PW-1:0]      pos_q;
  logic [PW-1:0]      cand_q;
  logic               busy_q;
  mftr_pkg::med_res_t res_q;

  logic [14:0]   cand;
  logic [CW-1:0] cnt_lt;
  logic [CW-1:0] cnt_le;
  logic          found;

  // Rank of the current candidate within the window
  always_comb begin
    cand   = win_q[cand_q];
    cnt_lt = '0;
    cnt_le = '0;
    for (int k = 0; k < WINDOW; k++) begin
      cnt_lt = cnt_lt + CW'(win_q[k] < cand);
      cnt_le = cnt_le + CW'(win_q[k] <= cand);
    end
    found = (cnt_lt <= Mid) && (cnt_le > Mid);
  end

  // Window storage and scan sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WINDOW; k++) win_q[k] <= '0;
      pos_q  <= '0;
      cand_q <= '0;
      busy_q <= 1'b0;
      res_q  <= '0;
    end else begin
      res_q.done <= 1'b0;
      if (clear_i) begin
        for (int k = 0; k < WINDOW; k++) win_q[k] <= '0;
        pos_q  <= '0;
        busy_q <= 1'b0;
      end else if (push_i) begin
        win_q[pos_q] <= push_data_i;
        pos_q  <= (pos_q == LastPos) ? '0 : pos_q + 1'b1;
        cand_q <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (found) begin
          busy_q      <= 1'b0;
          res_q.done  <= 1'b1;
          res_q.value <= cand;
        end else begin
          cand_q <= cand_q + 1'b1;
        end
      end
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

### hw/rtl/mftr_tone_search.sv
`default_nettype none

// Walks the data tones and then the two guards through one shared
// absolute-difference compare, first match wins.
module mftr_tone_search #(
  parameter int unsigned BITS_PER_SYMBOL = 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [14:0]        med_i,
  input  mftr_pkg::cfg_t          cfg_i,
  output mftr_pkg::tone_res_t     res_o
);

  localparam int unsigned NumTones = 1 << BITS_PER_SYMBOL;
  localparam int unsigned TW = (((13 + BITS_PER_SYMBOL) > 15) ? (13 + BITS_PER_SYMBOL) : 15) + 1;
  localparam int unsigned IW = BITS_PER_SYMBOL + 1;
  localparam logic [IW-1:0] IdxGuardA = IW'(NumTones);
  localparam logic [IW-1:0] IdxGuardB = IW'(NumTones + 1);

  logic                busy_q;
  logic [IW-1:0]       idx_q;
  logic [TW-1:0]       tone_q;
  mftr_pkg::tone_res_t res_q;

  logic [TW-1:0] target;
  logic [TW-1:0] med_ext;
  logic [TW-1:0] diff;
  logic          is_data;
  logic          near;

  // Shared compare unit
  always_comb begin
    med_ext = TW'(med_i);
    is_data = (idx_q < IdxGuardA);
    if (is_data) begin
      target = tone_q;
    end else if (idx_q == IdxGuardA) begin
      target = TW'(cfg_i.guard_a_hz);
    end else begin
      target = TW'(cfg_i.guard_b_hz);
    end
    diff = (med_ext > target) ? (med_ext - target) : (target - med_ext);
    near = (diff < TW'(cfg_i.match_tolerance_hz));
  end

  // Search sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      tone_q <= '0;
      res_q  <= '0;
    end else begin
      res_q.done <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
        tone_q <= TW'(cfg_i.base_tone_hz);
      end else if (busy_q) begin
        if (near || (idx_q == IdxGuardB)) begin
          busy_q           <= 1'b0;
          res_q.done       <= 1'b1;
          res_q.hit        <= near;
          res_q.is_data    <= is_data;
          res_q.eq_guard_a <= (target == TW'(cfg_i.guard_a_hz));
          res_q.eq_guard_b <= (target == TW'(cfg_i.guard_b_hz));
          res_q.sym        <= 8'(idx_q[BITS_PER_SYMBOL-1:0]);
        end else begin
          idx_q  <= idx_q + 1'b1;
          tone_q <= tone_q + TW'(cfg_i.tone_spacing_hz);
        end
      end
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

### hw/rtl/mfsk_tone_frame_receiver.sv
`default_nettype none

// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_stall_o   mftr_pkg::in_item_t  (mode, freq_hz)
// out      output     out_valid_o/out_stall_i mftr_pkg::out_item_t (one result per frame)
// cfg      input      cfg_we_i                cfg_index_i, cfg_wdata_i
//
// A restart or a frame in the complete phase goes from idle straight to the result
// state. Other frames first pass the median rank scan and the tone search; the rank
// scan and the single shared tone comparator set how long a frame is in work.
// in_stall_o is high while a frame is in work; a result waiting in the output
// register does not block the next input transfer, only the next result load.
// Reset is asynchronous and clears all state but the output data register, the registers take their defaults.
module mfsk_tone_frame_receiver #(
  parameter int unsigned WINDOW          = 9,
  parameter int unsigned BITS_PER_SYMBOL = 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_stall_o,
  input  mftr_pkg::in_item_t     in_data_i,
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output mftr_pkg::out_item_t    out_data_o,
  input  wire logic              cfg_we_i,
  input  wire logic [2:0]        cfg_index_i,
  input  wire logic [14:0]       cfg_wdata_i
);

  localparam int unsigned TonesPerByte = 8 / BITS_PER_SYMBOL;
  localparam logic [3:0]  HoldMin      = 4'(WINDOW - 1);
  localparam logic [3:0]  HoldReset    = 4'(WINDOW);
  localparam logic [3:0]  HoldMax      = 4'd15;

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StMedian = 2'd1;
  localparam logic [1:0] StMatch  = 2'd2;
  localparam logic [1:0] StResult = 2'd3;

  mftr_pkg::cfg_t      cfg_q;
  logic [1:0]          state_q, state_d;
  logic [3:0]          holdoff_q, holdoff_d;
  logic [2:0]          phase_q, phase_d;
  logic [7:0]          hdr_acc_q, hdr_acc_d;
  logic [3:0]          hdr_cnt_q, hdr_cnt_d;
  logic [7:0]          byte_acc_q, byte_acc_d;
  logic [3:0]          bitpos_q, bitpos_d;
  logic [7:0]          bytes_done_q, bytes_done_d;
  logic [7:0]          length_q, length_d;
  logic                acc_q, acc_d;
  logic                bvalid_q, bvalid_d;
  logic [7:0]          bvalue_q, bvalue_d;
  logic                blast_q, blast_d;
  logic                out_valid_q;
  mftr_pkg::out_item_t out_data_q;

  logic                in_xfer;
  logic                push;
  logic                restart;
  logic                out_load;
  mftr_pkg::med_res_t  med_res;
  mftr_pkg::tone_res_t tone_res;

  assign in_stall_o = (state_q != StIdle);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign restart    = in_xfer && in_data_i.mode;
  assign push       = in_xfer && !in_data_i.mode && (phase_q != mftr_pkg::PhDone);
  assign out_load   = (state_q == StResult) && (!out_valid_q || !out_stall_i);

  mftr_median #(
    .WINDOW (WINDOW)
  ) u_median (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (restart),
    .push_i      (push),
    .push_data_i (in_data_i.freq_hz),
    .res_o       (med_res)
  );

  mftr_tone_search #(
    .BITS_PER_SYMBOL (BITS_PER_SYMBOL)
  ) u_search (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (med_res.done && (state_q == StMedian)),
    .med_i   (med_res.value),
    .cfg_i   (cfg_q),
    .res_o   (tone_res)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_tone_hz       <= 15'd1000;
      cfg_q.tone_spacing_hz    <= 13'd100;
      cfg_q.guard_a_hz         <= 15'd5000;
      cfg_q.guard_b_hz         <= 15'd5500;
      cfg_q.match_tolerance_hz <= 12'd40;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mftr_pkg::CfgBaseTone:  cfg_q.base_tone_hz       <= cfg_wdata_i;
        mftr_pkg::CfgSpacing:   cfg_q.tone_spacing_hz    <= cfg_wdata_i[12:0];
        mftr_pkg::CfgGuardA:    cfg_q.guard_a_hz         <= cfg_wdata_i;
        mftr_pkg::CfgGuardB:    cfg_q.guard_b_hz         <= cfg_wdata_i;
        mftr_pkg::CfgTolerance: cfg_q.match_tolerance_hz <= cfg_wdata_i[11:0];
        default: ;
      endcase
    end
  end

  // Sequencer, hold-off and framing state machine
  always_comb begin
    logic [3:0] hdr_sh;
    logic [3:0] body_sh;
    logic [7:0] sym8;
    logic [3:0] bitpos_nx;
    logic [7:0] bytes_nx;

    state_d      = state_q;
    holdoff_d    = holdoff_q;
    phase_d      = phase_q;
    hdr_acc_d    = hdr_acc_q;
    hdr_cnt_d    = hdr_cnt_q;
    byte_acc_d   = byte_acc_q;
    bitpos_d     = bitpos_q;
    bytes_done_d = bytes_done_q;
    length_d     = length_q;
    acc_d        = acc_q;
    bvalid_d     = bvalid_q;
    bvalue_d     = bvalue_q;
    blast_d      = blast_q;

    sym8      = tone_res.sym;
    hdr_sh    = 4'(8 - BITS_PER_SYMBOL - int'(hdr_cnt_q) * BITS_PER_SYMBOL);
    body_sh   = 4'(8 - BITS_PER_SYMBOL - int'(bitpos_q));
    bitpos_nx = bitpos_q + 4'(BITS_PER_SYMBOL);
    bytes_nx  = bytes_done_q + 8'd1;

    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          acc_d    = 1'b0;
          bvalid_d = 1'b0;
          bvalue_d = '0;
          blast_d  = 1'b0;
          if (in_data_i.mode) begin
            holdoff_d    = HoldReset;
            phase_d      = mftr_pkg::PhWaitA;
            hdr_acc_d    = '0;
            hdr_cnt_d    = '0;
            byte_acc_d   = '0;
            bitpos_d     = '0;
            bytes_done_d = '0;
            length_d     = '0;
            state_d      = StResult;
          end else if (phase_q == mftr_pkg::PhDone) begin
            state_d = StResult;
          end else begin
            if (holdoff_q < HoldMax) holdoff_d = holdoff_q + 4'd1;
            state_d = StMedian;
          end
        end
      end
      StMedian: begin
        if (med_res.done) state_d = StMatch;
      end
      StMatch: begin
        if (tone_res.done) begin
          state_d = StResult;
          if (tone_res.hit && (holdoff_q >= HoldMin)) begin
            holdoff_d = '0;
            acc_d     = 1'b1;
            unique case (phase_q)
              mftr_pkg::PhWaitA: begin
                if (tone_res.eq_guard_a) phase_d = mftr_pkg::PhSawA;
              end
              mftr_pkg::PhSawA: begin
                phase_d = tone_res.eq_guard_b ? mftr_pkg::PhHeader : mftr_pkg::PhWaitA;
              end
              mftr_pkg::PhHeader: begin
                if (tone_res.is_data) begin
                  hdr_acc_d = hdr_acc_q + (sym8 << hdr_sh);
                  hdr_cnt_d = hdr_cnt_q + 4'd1;
                  if (hdr_cnt_d >= 4'(TonesPerByte)) begin
                    length_d = hdr_acc_d;
                    phase_d  = (hdr_acc_d == 8'd0) ? mftr_pkg::PhDone : mftr_pkg::PhBody;
                  end
                end
              end
              mftr_pkg::PhBody: begin
                if (tone_res.is_data) begin
                  byte_acc_d = byte_acc_q + (sym8 << body_sh);
                  bitpos_d   = bitpos_nx;
                  if ((5'(bitpos_nx) + 5'(BITS_PER_SYMBOL)) > 5'd8) begin
                    bvalid_d     = 1'b1;
                    bvalue_d     = byte_acc_d;
                    byte_acc_d   = '0;
                    bitpos_d     = '0;
                    bytes_done_d = bytes_nx;
                    if (bytes_nx == length_q) begin
                      blast_d = 1'b1;
                      phase_d = mftr_pkg::PhDone;
                    end
                  end
                end
              end
              default: ;
            endcase
          end
        end
      end
      StResult: begin
        if (out_load) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      holdoff_q    <= HoldReset;
      phase_q      <= mftr_pkg::PhWaitA;
      hdr_acc_q    <= '0;
      hdr_cnt_q    <= '0;
      byte_acc_q   <= '0;
      bitpos_q     <= '0;
      bytes_done_q <= '0;
      length_q     <= '0;
      acc_q        <= 1'b0;
      bvalid_q     <= 1'b0;
      bvalue_q     <= '0;
      blast_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      holdoff_q    <= holdoff_d;
      phase_q      <= phase_d;
      hdr_acc_q    <= hdr_acc_d;
      hdr_cnt_q    <= hdr_cnt_d;
      byte_acc_q   <= byte_acc_d;
      bitpos_q     <= bitpos_d;
      bytes_done_q <= bytes_done_d;
      length_q     <= length_d;
      acc_q        <= acc_d;
      bvalid_q     <= bvalid_d;
      bvalue_q     <= bvalue_d;
      blast_q      <= blast_d;
    end
  end

  // Output register, loaded when empty or when its transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.phase         <= phase_q;
      out_data_q.tone_accepted <= acc_q;
      out_data_q.byte_valid    <= bvalid_q;
      out_data_q.byte_value    <= bvalue_q;
      out_data_q.byte_last     <= blast_q;
      out_data_q.body_length   <= length_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Checks
  a_last_ends_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.byte_last |->
      out_data_o.byte_valid && (out_data_o.phase == mftr_pkg::PhDone))
    else $error("byte_last without a completing byte");

  a_byte_needs_tone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.byte_valid |-> out_data_o.tone_accepted)
    else $error("byte completed without an accepted tone");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart |=> (phase_q == mftr_pkg::PhWaitA) && (length_q == 8'd0) &&
                (holdoff_q == HoldReset))
    else $error("restart did not clear the framing state");

endmodule

`default_nettype wire

### tb/mfsk_tone_frame_receiver_checker.sv
`timescale 1ns / 100ps

// Watches the frame and report channels, predicts each report and compares it
module mfsk_tone_frame_receiver_checker #(
  parameter int unsigned WINDOW          = 9,
  parameter int unsigned BITS_PER_SYMBOL = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  mftr_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  mftr_pkg::out_item_t out_data_i,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [14:0]         cfg_wdata_i,
  output int                  mismatches_o,
  output int                  pending_o
);

  localparam int unsigned NumTones     = 1 << BITS_PER_SYMBOL;
  localparam int unsigned TonesPerByte = 8 / BITS_PER_SYMBOL;
  localparam int unsigned HoldoffMax   = 15;
  localparam int unsigned MaxReports   = 100;
  // base, spacing, guard a, guard b, tolerance
  localparam mftr_pkg::cfg_t CfgDefaults = {15'd1000, 13'd100, 15'd5000, 15'd5500, 12'd40};

  // Receiver settings as last written
  mftr_pkg::cfg_t rx_cfg = CfgDefaults;

  // Predicted receiver state
  logic [14:0] win [WINDOW];
  int unsigned win_pos;
  int unsigned holdoff;
  logic [2:0]  phase;
  logic [7:0]  hdr_acc;
  int unsigned hdr_tones;
  logic [7:0]  byte_acc;
  int unsigned bit_pos;
  logic [7:0]  bytes_done;
  logic [7:0]  body_len;

  mftr_pkg::out_item_t predicted_reports_q [$];
  int unsigned mismatch_count = 0;
  int unsigned shown = 0;

  function automatic void clear_receiver();
    for (int i = 0; i < WINDOW; i++) win[i] = '0;
    win_pos    = 0;
    holdoff    = WINDOW;
    phase      = mftr_pkg::PhWaitA;
    hdr_acc    = '0;
    hdr_tones  = 0;
    byte_acc   = '0;
    bit_pos    = 0;
    bytes_done = '0;
    body_len   = '0;
  endfunction

  // Insertion sort of the window, middle rank
  function automatic logic [14:0] window_median();
    logic [14:0] s [WINDOW];
    logic [14:0] v;
    int          j;
    for (int i = 0; i < WINDOW; i++) begin
      v = win[i];
      j = i;
      while (j > 0 && s[j-1] > v) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = v;
    end
    return s[WINDOW/2];
  endfunction

  function automatic logic near_tone(int unsigned f, int unsigned tone);
    int unsigned d;
    d = (f > tone) ? f - tone : tone - f;
    return d < rx_cfg.match_tolerance_hz;
  endfunction

  // One frame through the demodulator: window, median, tone match, framing
  function automatic mftr_pkg::out_item_t demodulate_frame(mftr_pkg::in_item_t frame);
    mftr_pkg::out_item_t r;
    int unsigned med, tone, tone_f, sym, sh;
    logic        hit, is_data;
    r = '0;
    if (frame.mode) begin
      clear_receiver();
    end else if (phase != mftr_pkg::PhDone) begin
      if (holdoff < HoldoffMax) holdoff++;
      win[win_pos] = frame.freq_hz;
      win_pos = (win_pos + 1) % WINDOW;
      med = window_median();
      hit = 1'b0;
      is_data = 1'b0;
      sym = 0;
      tone_f = 0;
      // data tones first, then guard a, then guard b
      for (int i = 0; i < NumTones; i++) begin
        tone = rx_cfg.base_tone_hz;
        tone += i * rx_cfg.tone_spacing_hz;
        if (!hit && near_tone(med, tone)) begin
          hit = 1'b1;
          is_data = 1'b1;
          sym = i;
          tone_f = tone;
        end
      end
      if (!hit && near_tone(med, rx_cfg.guard_a_hz)) begin
        hit = 1'b1;
        tone_f = rx_cfg.guard_a_hz;
      end
      if (!hit && near_tone(med, rx_cfg.guard_b_hz)) begin
        hit = 1'b1;
        tone_f = rx_cfg.guard_b_hz;
      end

      if (hit && holdoff >= WINDOW - 1) begin
        holdoff = 0;
        r.tone_accepted = 1'b1;
        case (phase)
          mftr_pkg::PhWaitA: begin
            if (tone_f == rx_cfg.guard_a_hz) phase = mftr_pkg::PhSawA;
          end
          mftr_pkg::PhSawA: begin
            phase = (tone_f == rx_cfg.guard_b_hz) ? mftr_pkg::PhHeader : mftr_pkg::PhWaitA;
          end
          mftr_pkg::PhHeader: begin
            if (is_data) begin
              sh = 8 - BITS_PER_SYMBOL - hdr_tones * BITS_PER_SYMBOL;
              hdr_acc = hdr_acc + 8'(sym << sh);
              hdr_tones++;
              if (hdr_tones >= TonesPerByte) begin
                body_len = hdr_acc;
                phase = (body_len == 0) ? mftr_pkg::PhDone : mftr_pkg::PhBody;
              end
            end
          end
          mftr_pkg::PhBody: begin
            if (is_data) begin
              sh = 8 - BITS_PER_SYMBOL - bit_pos;
              byte_acc = byte_acc + 8'(sym << sh);
              bit_pos += BITS_PER_SYMBOL;
              if (bit_pos + BITS_PER_SYMBOL > 8) begin
                r.byte_valid = 1'b1;
                r.byte_value = byte_acc;
                byte_acc = '0;
                bit_pos = 0;
                bytes_done = bytes_done + 8'd1;
                if (bytes_done == body_len) begin
                  r.byte_last = 1'b1;
                  phase = mftr_pkg::PhDone;
                end
              end
            end
          end
          default: ;
        endcase
      end
    end
    r.phase = phase;
    r.body_length = body_len;
    return r;
  endfunction

  function automatic void write_setting(logic [2:0] idx, logic [14:0] data);
    case (idx)
      mftr_pkg::CfgBaseTone:  rx_cfg.base_tone_hz = data;
      mftr_pkg::CfgSpacing:   rx_cfg.tone_spacing_hz = data[12:0];
      mftr_pkg::CfgGuardA:    rx_cfg.guard_a_hz = data;
      mftr_pkg::CfgGuardB:    rx_cfg.guard_b_hz = data;
      mftr_pkg::CfgTolerance: rx_cfg.match_tolerance_hz = data[11:0];
      default: ;
    endcase
  endfunction

  function automatic void check_report(mftr_pkg::out_item_t got);
    mftr_pkg::out_item_t want;
    if (predicted_reports_q.size() == 0) begin
      mismatch_count++;
      if (shown < MaxReports) begin
        shown++;
        $display("%0t: unexpected report, expected none, actual %h", $time, got);
      end
    end else begin
      want = predicted_reports_q.pop_front();
      if (got.phase !== want.phase || got.tone_accepted !== want.tone_accepted ||
          got.byte_valid !== want.byte_valid || got.byte_value !== want.byte_value ||
          got.byte_last !== want.byte_last || got.body_length !== want.body_length) begin
        mismatch_count++;
        if (shown < MaxReports) begin
          shown++;
          $display("%0t: report mismatch, expected phase=%0d acc=%0b bv=%0b byte=%02h ",
                   $time, want.phase, want.tone_accepted, want.byte_valid, want.byte_value,
                   "last=%0b len=%0d, actual phase=%0d acc=%0b bv=%0b byte=%02h ",
                   want.byte_last, want.body_length, got.phase, got.tone_accepted,
                   got.byte_valid, got.byte_value,
                   "last=%0b len=%0d", got.byte_last, got.body_length);
        end
      end
    end
  endfunction

  // Sample both channels and the settings port at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_cfg = CfgDefaults;
      clear_receiver();
      predicted_reports_q.delete();
      pending_o <= 0;
      mismatches_o <= mismatch_count;
    end else begin
      if (out_valid_i && !out_stall_i) check_report(out_data_i);
      if (in_valid_i && !in_stall_i) predicted_reports_q.push_back(demodulate_frame(in_data_i));
      if (cfg_we_i) write_setting(cfg_index_i, cfg_wdata_i);
      pending_o <= predicted_reports_q.size();
      mismatches_o <= mismatch_count;
    end
  end

endmodule

### tb/mfsk_tone_frame_receiver_tb.sv
`timescale 1ns / 100ps

module mfsk_tone_frame_receiver_tb;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned HoldCycles    = 250;
  localparam int unsigned SettleCycles  = 30;
  localparam int unsigned MaxFreq       = 32767;
  localparam int unsigned SymBits       = 2;
  localparam int unsigned SymsPerByte   = 8 / SymBits;
  localparam int unsigned SymMask       = (1 << SymBits) - 1;
  // base, spacing, guard a, guard b, tolerance
  localparam mftr_pkg::cfg_t CfgDefaults = {15'd1000, 13'd100, 15'd5000, 15'd5500, 12'd40};

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  mftr_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  mftr_pkg::out_item_t out_data;
  logic                cfg_we = 1'b0;
  logic [2:0]          cfg_index = mftr_pkg::CfgBaseTone;
  logic [14:0]         cfg_wdata = '0;

  int             mismatches;
  int             pending;
  int unsigned    idle_max = 14;
  int unsigned    frames_sent = 0;
  int unsigned    quiet_cycles = 0;
  mftr_pkg::cfg_t tx_cfg = CfgDefaults;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  mfsk_tone_frame_receiver dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  mfsk_tone_frame_receiver_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Report sink: random stalls, two long hold-offs to back the block up
  initial begin : report_sink
    int unsigned n, taken;
    taken = 0;
    @(posedge rst_n);
    forever begin
      n = (taken == 300 || taken == 1300) ? HoldCycles : $urandom_range(idle_max, 0);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  function automatic mftr_pkg::cfg_t make_cfg(int unsigned base, int unsigned spacing,
                                              int unsigned ga, int unsigned gb,
                                              int unsigned tol);
    mftr_pkg::cfg_t c;
    c.base_tone_hz       = 15'(base);
    c.tone_spacing_hz    = 13'(spacing);
    c.guard_a_hz         = 15'(ga);
    c.guard_b_hz         = 15'(gb);
    c.match_tolerance_hz = 12'(tol);
    return c;
  endfunction

  function automatic int unsigned tone_hz(int unsigned sym);
    return tx_cfg.base_tone_hz + sym * tx_cfg.tone_spacing_hz;
  endfunction

  // One frame transfer after a random gap; valid stays up across back-to-back frames
  task automatic send_frame(logic mode, int unsigned freq);
    mftr_pkg::in_item_t item;
    int unsigned        gap;
    gap = $urandom_range(idle_max, 0);
    item.mode = mode;
    item.freq_hz = 15'((freq > MaxFreq) ? MaxFreq : freq);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    frames_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending and wait until every report is back
  task automatic drain_reports();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic load_config(mftr_pkg::cfg_t c);
    cfg_we <= 1'b1;
    cfg_index <= mftr_pkg::CfgBaseTone;
    cfg_wdata <= c.base_tone_hz;
    @(posedge clk);
    cfg_index <= mftr_pkg::CfgSpacing;
    cfg_wdata <= 15'(c.tone_spacing_hz);
    @(posedge clk);
    cfg_index <= mftr_pkg::CfgGuardA;
    cfg_wdata <= c.guard_a_hz;
    @(posedge clk);
    cfg_index <= mftr_pkg::CfgGuardB;
    cfg_wdata <= c.guard_b_hz;
    @(posedge clk);
    cfg_index <= mftr_pkg::CfgTolerance;
    cfg_wdata <= 15'(c.match_tolerance_hz);
    @(posedge clk);
    cfg_we <= 1'b0;
    tx_cfg = c;
  endtask

  // A run of frames near one tone, with jitter inside tolerance and rare outliers
  task automatic send_tone(int unsigned f, int unsigned run);
    int unsigned j;
    int          v;
    j = tx_cfg.match_tolerance_hz / 3;
    for (int n = 0; n < run; n++) begin
      v = int'(f) + int'($urandom_range(2 * j, 0)) - int'(j);
      if (v < 0) v = 0;
      if ($urandom_range(15, 0) == 0) v = $urandom_range(MaxFreq, 0);
      send_frame(1'b0, v);
    end
  endtask

  // Data symbol, now and then preceded by a stray guard tone
  task automatic send_symbol(int unsigned sym, int unsigned run);
    if ($urandom_range(24, 0) == 0)
      send_tone($urandom_range(1, 0) ? tx_cfg.guard_a_hz : tx_cfg.guard_b_hz, run);
    send_tone(tone_hz(sym), run);
  endtask

  // Restart, guards, length header, body bytes, then a few frames past the end
  task automatic send_transfer();
    int unsigned run, len;
    logic [7:0]  b;
    run = ($urandom_range(4, 0) == 0) ? $urandom_range(10, 6) : 8;
    if ($urandom_range(7, 0) == 0) len = 0;
    else if ($urandom_range(15, 0) == 0) len = $urandom_range(12, 5);
    else len = $urandom_range(3, 1);
    send_frame(1'b1, $urandom_range(MaxFreq, 0));
    send_tone(tx_cfg.guard_a_hz, run);
    send_tone(tx_cfg.guard_b_hz, run);
    for (int k = 0; k < SymsPerByte; k++)
      send_symbol((len >> (8 - SymBits - k * SymBits)) & SymMask, run);
    for (int i = 0; i < len; i++) begin
      b = $urandom_range(255, 0);
      for (int k = 0; k < SymsPerByte; k++)
        send_symbol((b >> (8 - SymBits - k * SymBits)) & SymMask, run);
    end
    repeat ($urandom_range(3, 0)) send_frame(1'b0, $urandom_range(MaxFreq, 0));
  endtask

  // Noise and broken preambles
  task automatic send_noise();
    case ($urandom_range(3, 0))
      0: begin
        repeat ($urandom_range(12, 1))
          send_frame($urandom_range(7, 0) == 0, $urandom_range(MaxFreq, 0));
      end
      1: begin
        send_frame(1'b1, $urandom_range(MaxFreq, 0));
        send_tone(tx_cfg.guard_a_hz, 8);
        send_tone(tone_hz($urandom_range(SymMask, 0)), 8);
      end
      2: begin
        send_frame(1'b1, $urandom_range(MaxFreq, 0));
        send_tone(tx_cfg.guard_a_hz, 8);
        send_tone(tx_cfg.guard_a_hz, 8);
        send_tone(tx_cfg.guard_b_hz, 8);
      end
      default: begin
        send_frame(1'b1, $urandom_range(MaxFreq, 0));
        send_tone(tx_cfg.guard_a_hz, 8);
        send_tone(tx_cfg.guard_b_hz, 8);
        send_tone(tone_hz($urandom_range(SymMask, 0)), 8);
        send_tone(tone_hz($urandom_range(SymMask, 0)), 8);
      end
    endcase
  endtask

  // One settings phase: write all registers, then mostly clean transfers
  task automatic run_phase(mftr_pkg::cfg_t c, int unsigned budget);
    int unsigned stop;
    load_config(c);
    stop = frames_sent + budget;
    while (frames_sent < stop) begin
      idle_max = ($urandom_range(3, 0) == 0) ? 0 : 14;
      if ($urandom_range(3, 0) != 0) send_transfer();
      else send_noise();
    end
    drain_reports();
  endtask

  initial begin : stimulus
    int unsigned spacing;
    @(posedge rst_n);
    @(posedge clk);

    // Field extremes and restarts at reset settings
    send_frame(1'b0, 0);
    send_frame(1'b0, MaxFreq);
    send_frame(1'b0, MaxFreq);
    send_frame(1'b1, MaxFreq);
    send_frame(1'b0, 15'h5555);
    send_frame(1'b0, 15'h2aaa);
    send_frame(1'b0, 16384);
    send_frame(1'b1, 0);
    send_tone(tx_cfg.guard_a_hz, 8);
    send_tone(tx_cfg.guard_b_hz, 8);
    drain_reports();

    run_phase(make_cfg(1000, 100, 5000, 5500, 40), 180);
    // exact matching, tones at 0..3 Hz, symbol zero at 0 Hz
    run_phase(make_cfg(0, 1, 10, 20, 1), 120);
    // everything at the top of its range but guard b, which sits at zero
    run_phase(make_cfg(MaxFreq, 8191, MaxFreq, 0, 4095), 60);
    // zero tolerance: nothing ever matches
    run_phase(make_cfg(3000, 200, 7000, 9000, 0), 30);
    // guards sit on data tones
    run_phase(make_cfg(2000, 250, 2250, 2750, 100), 150);
    // top data tone lands past the frequency range
    run_phase(make_cfg(32000, 300, 100, 31000, 120), 120);
    repeat (3) begin
      spacing = $urandom_range(3000, 50);
      run_phase(make_cfg($urandom_range(20000, 0), spacing, $urandom_range(MaxFreq, 0),
                         $urandom_range(MaxFreq, 0), $urandom_range(spacing / 2, 10)), 150);
    end

    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
